[rtl/hst_pkg.sv]
`timescale 1ns / 1ps

package hst_pkg;

    // Default geometry
    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int WORD_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP     = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEF_TOKEN  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEF_NUMBER = 2'd2;

    // Entry kinds
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNDEF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOKEN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNDEF   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    // Key mixing constants
    localparam logic [WORD_W-1:0] MIX_C0 = 32'h7ed55d16;
    localparam logic [WORD_W-1:0] MIX_C1 = 32'hc761c23c;
    localparam logic [WORD_W-1:0] MIX_C2 = 32'h165667b1;
    localparam logic [WORD_W-1:0] MIX_C3 = 32'hd3a2646c;
    localparam logic [WORD_W-1:0] MIX_C4 = 32'hfd7046c5;
    localparam logic [WORD_W-1:0] MIX_C5 = 32'hb55a4f09;

    typedef enum logic [1:0] {
        HS_IDLE,
        HS_MIX,
        HS_MOD
    } hash_state_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_EVAL
    } state_t;

endpackage

[rtl/hst_req_if.sv]
`timescale 1ns / 1ps

interface hst_req_if;
    logic                                valid;
    logic                                ready;
    logic        [hst_pkg::FUNC_W-1:0]   func;
    logic        [hst_pkg::WORD_W-1:0]   key;
    logic signed [hst_pkg::WORD_W-1:0]   value;

    modport source (output valid, output func, output key, output value, input ready);
    modport sink   (input valid, input func, input key, input value, output ready);
endinterface

[rtl/hst_rsp_if.sv]
`timescale 1ns / 1ps

interface hst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [hst_pkg::WORD_W-1:0]   result_value;
    logic        [hst_pkg::STATUS_W-1:0] status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

[rtl/hst_ram.sv]
`timescale 1ns / 1ps

module hst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/hst_hash.sv]
`timescale 1ns / 1ps

module hst_hash #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [hst_pkg::WORD_W-1:0]   key,
    output logic                         done,
    output logic [$clog2(BUCKETS)-1:0]   bucket
);

    localparam int BW = $clog2(BUCKETS);
    localparam int PW = 2 * hst_pkg::WORD_W;
    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [2:0] LAST_STEP = 3'd5;
    localparam logic [1:0] LAST_MOD = 2'd2;
    // Scaled reciprocal of the bucket count; the quotient estimate is low by at most one
    localparam int SHIFT = hst_pkg::WORD_W - 1 + BW;
    localparam logic [PW-1:0] SCALE = PW'(1) << SHIFT;
    localparam logic [hst_pkg::WORD_W-1:0] RECIP = hst_pkg::WORD_W'(SCALE / PW'(BUCKETS));
    localparam logic [hst_pkg::WORD_W-1:0] DIVISOR = hst_pkg::WORD_W'(BUCKETS);

    hst_pkg::hash_state_t state_reg, state_next;
    logic [2:0]                   step_reg, step_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic [hst_pkg::WORD_W-1:0]   k_reg, k_next;
    logic [PW-1:0]                prod_reg, prod_next;
    logic [hst_pkg::WORD_W-1:0]   part_reg, part_next;
    logic [BW-1:0]                rem_reg, rem_next;
    logic                         done_reg, done_next;

    function automatic logic [hst_pkg::WORD_W-1:0] mix_step(
        input logic [hst_pkg::WORD_W-1:0] k,
        input logic [2:0]                 step
    );
        logic [hst_pkg::WORD_W-1:0] r;
        case (step)
            3'd0:    r = (k + hst_pkg::MIX_C0) + (k << 12);
            3'd1:    r = (k ^ hst_pkg::MIX_C1) ^ (k >> 19);
            3'd2:    r = (k + hst_pkg::MIX_C2) + (k << 5);
            3'd3:    r = (k + hst_pkg::MIX_C3) ^ (k << 9);
            3'd4:    r = (k + hst_pkg::MIX_C4) + (k << 3);
            default: r = (k ^ hst_pkg::MIX_C5) ^ (k >> 16);
        endcase
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hst_pkg::HS_IDLE:
            begin
                if (start)
                begin
                    state_next = hst_pkg::HS_MIX;
                end
            end
            hst_pkg::HS_MIX:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = POW2 ? hst_pkg::HS_IDLE : hst_pkg::HS_MOD;
                end
            end
            hst_pkg::HS_MOD:
            begin
                if (cnt_reg == LAST_MOD)
                begin
                    state_next = hst_pkg::HS_IDLE;
                end
            end
            default: state_next = hst_pkg::HS_IDLE;
        endcase
    end

    always_comb
    begin
        k_next    = k_reg;
        step_next = step_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        part_next = part_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        case (state_reg)
            hst_pkg::HS_IDLE:
            begin
                if (start)
                begin
                    k_next    = key;
                    step_next = '0;
                end
            end
            hst_pkg::HS_MIX:
            begin
                k_next    = mix_step(k_reg, step_reg);
                step_next = step_reg + 3'd1;
                cnt_next  = '0;
                rem_next  = '0;
                done_next = POW2 && (step_reg == LAST_STEP);
            end
            hst_pkg::HS_MOD:
            begin
                // Estimate the quotient, take the partial remainder, correct once
                case (cnt_reg)
                    2'd0:
                    begin
                        prod_next = PW'(k_reg) * PW'(RECIP);
                    end
                    2'd1:
                    begin
                        part_next = k_reg - hst_pkg::WORD_W'(prod_reg >> SHIFT) * DIVISOR;
                    end
                    default:
                    begin
                        rem_next = (part_reg >= DIVISOR) ? BW'(part_reg - DIVISOR)
                                                         : BW'(part_reg);
                    end
                endcase
                cnt_next  = cnt_reg + 2'd1;
                done_next = (cnt_reg == LAST_MOD);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hst_pkg::HS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        step_reg <= step_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        part_reg <= part_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = POW2 ? k_reg[BW-1:0] : rem_reg;

endmodule

[rtl/hashed_symbol_table.sv]
`timescale 1ns / 1ps

// Hardware symbol table with a set-associative store of BUCKETS x WAYS entries.
// Channels: req carries func, key and value; rsp carries result_value and status.
// Both transfer on a clock edge where valid and ready are high; every request
// produces exactly one response, in order.
// Each key is mixed by a six-step integer hash, one step per cycle in the hash
// unit; when BUCKETS is not a power of two it is then reduced to a bucket by
// a scaled reciprocal multiply and one correction. The bucket row is next
// read from the kind and data memories (registered), compared across all ways
// and written back when an entry changes.
// A new request is taken only after the previous one has left evaluation.
// The response sits in an output register, so a new request is accepted while
// the previous response still waits. If the receiver stalls with a response
// held and the next one is ready, the block holds in evaluation until the
// output register frees up.
// Reset: clears control state, then sweeps the kind memory one bucket per cycle,
// marking all entries free; req.ready stays low meanwhile.
module hashed_symbol_table #(
    parameter int BUCKETS = hst_pkg::BUCKETS_DEF,
    parameter int WAYS    = hst_pkg::WAYS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hst_req_if.sink   req,
    hst_rsp_if.source rsp
);

    localparam int BW      = $clog2(BUCKETS);
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KW      = hst_pkg::KIND_W;
    localparam int DW      = 2 * hst_pkg::WORD_W;
    localparam int KROW_W  = WAYS * KW;
    localparam int DROW_W  = WAYS * DW;
    localparam logic [BW-1:0] LAST_ROW = BW'(BUCKETS - 1);

    hst_pkg::state_t state_reg, state_next;

    logic [BW-1:0]                      clr_reg, clr_next;
    logic [hst_pkg::FUNC_W-1:0]         func_reg;
    logic [hst_pkg::WORD_W-1:0]         key_reg;
    logic [hst_pkg::WORD_W-1:0]         value_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [hst_pkg::WORD_W-1:0]         out_value_reg, out_value_next;
    logic [hst_pkg::STATUS_W-1:0]       out_status_reg, out_status_next;

    logic                               accept;
    logic                               eval_go;
    logic                               hash_done;
    logic [BW-1:0]                      bucket;

    logic                               kind_wr_en;
    logic [BW-1:0]                      kind_wr_addr;
    logic [KROW_W-1:0]                  kind_wr_data;
    logic [KROW_W-1:0]                  kind_row;
    logic                               data_wr_en;
    logic [DROW_W-1:0]                  data_wr_data;
    logic [DROW_W-1:0]                  data_row;

    // Results of the bucket evaluation
    logic                               upd_en;
    logic [KROW_W-1:0]                  upd_kind_row;
    logic [DROW_W-1:0]                  upd_data_row;
    logic [hst_pkg::WORD_W-1:0]         res_value;
    logic [hst_pkg::STATUS_W-1:0]       res_status;

    assign accept  = req.valid && req.ready;
    assign eval_go = !out_valid_reg || rsp.ready;

    hst_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .key    (req.key),
        .done   (hash_done),
        .bucket (bucket)
    );

    // Kind memory: one row of way kinds per bucket
    hst_ram #(
        .WIDTH (KROW_W),
        .DEPTH (BUCKETS)
    ) u_kind_ram (
        .clk     (clk),
        .wr_en   (kind_wr_en),
        .wr_addr (kind_wr_addr),
        .wr_data (kind_wr_data),
        .rd_en   (hash_done),
        .rd_addr (bucket),
        .rd_data (kind_row)
    );

    // Data memory: one row of {value, key} per way per bucket
    hst_ram #(
        .WIDTH (DROW_W),
        .DEPTH (BUCKETS)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (bucket),
        .wr_data (data_wr_data),
        .rd_en   (hash_done),
        .rd_addr (bucket),
        .rd_data (data_row)
    );

    // Compare all ways of the bucket, pick the entry and work out its update
    always_comb
    begin
        logic                         hit;
        logic                         has_free;
        logic [WW-1:0]                hit_way;
        logic [WW-1:0]                free_way;
        logic [WW-1:0]                way;
        logic [KW-1:0]                kind;
        logic [KW-1:0]                new_kind;
        logic [hst_pkg::WORD_W-1:0]   new_value;
        logic [hst_pkg::WORD_W-1:0]   old_value;

        hit       = 1'b0;
        has_free  = 1'b0;
        hit_way   = '0;
        free_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (kind_row[w*KW +: KW] == hst_pkg::KIND_FREE)
            begin
                has_free = 1'b1;
                free_way = WW'(w);
            end
            else if (data_row[w*DW +: hst_pkg::WORD_W] == key_reg)
            begin
                hit     = 1'b1;
                hit_way = WW'(w);
            end
        end

        way       = hit ? hit_way : free_way;
        kind      = hit ? kind_row[way*KW +: KW] : hst_pkg::KIND_UNDEF;
        old_value = hit ? data_row[way*DW + hst_pkg::WORD_W +: hst_pkg::WORD_W] : '0;
        new_kind  = kind;
        new_value = old_value;
        res_value  = '0;
        res_status = hst_pkg::STATUS_UNDEF;
        upd_en     = 1'b0;

        case (func_reg)
            hst_pkg::FUNC_LOOKUP,
            hst_pkg::FUNC_DEF_TOKEN,
            hst_pkg::FUNC_DEF_NUMBER:
            begin
                if (!hit && !has_free)
                begin
                    res_status = hst_pkg::STATUS_FULL;
                end
                else
                begin
                    // A new key is always entered, even by a lookup
                    upd_en = !hit;
                    case (func_reg)
                        hst_pkg::FUNC_LOOKUP:
                        begin
                            if (kind inside {hst_pkg::KIND_TOKEN, hst_pkg::KIND_NUMBER})
                            begin
                                res_value  = old_value;
                                res_status = hst_pkg::STATUS_OK;
                            end
                        end
                        hst_pkg::FUNC_DEF_TOKEN:
                        begin
                            if (kind != hst_pkg::KIND_UNDEF)
                            begin
                                res_status = hst_pkg::STATUS_REFUSED;
                            end
                            else
                            begin
                                new_kind   = hst_pkg::KIND_TOKEN;
                                new_value  = value_reg;
                                res_value  = value_reg;
                                res_status = hst_pkg::STATUS_OK;
                                upd_en     = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (kind == hst_pkg::KIND_TOKEN)
                            begin
                                res_status = hst_pkg::STATUS_REFUSED;
                            end
                            else
                            begin
                                new_kind   = hst_pkg::KIND_NUMBER;
                                new_value  = value_reg;
                                res_value  = value_reg;
                                res_status = hst_pkg::STATUS_OK;
                                upd_en     = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: ;  // unused code: answer undefined, leave the store alone
        endcase

        upd_kind_row = kind_row;
        upd_kind_row[way*KW +: KW] = new_kind;
        upd_data_row = data_row;
        upd_data_row[way*DW +: DW] = {new_value, key_reg};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hst_pkg::S_CLEAR:
            begin
                if (clr_reg == LAST_ROW)
                begin
                    state_next = hst_pkg::S_IDLE;
                end
            end
            hst_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = hst_pkg::S_HASH;
                end
            end
            hst_pkg::S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = hst_pkg::S_EVAL;
                end
            end
            hst_pkg::S_EVAL:
            begin
                if (eval_go)
                begin
                    state_next = hst_pkg::S_IDLE;
                end
            end
            default: state_next = hst_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath control
    always_comb
    begin
        req.ready       = 1'b0;
        clr_next        = clr_reg;
        kind_wr_en      = 1'b0;
        kind_wr_addr    = bucket;
        kind_wr_data    = upd_kind_row;
        data_wr_en      = 1'b0;
        data_wr_data    = upd_data_row;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            hst_pkg::S_CLEAR:
            begin
                // Mark one bucket free per cycle
                kind_wr_en   = 1'b1;
                kind_wr_addr = clr_reg;
                kind_wr_data = '0;
                clr_next     = clr_reg + 1'b1;
            end
            hst_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            hst_pkg::S_EVAL:
            begin
                if (eval_go)
                begin
                    kind_wr_en      = upd_en;
                    data_wr_en      = upd_en;
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value;
                    out_status_next = res_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hst_pkg::S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request fields for the whole operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= req.func;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import hst_pkg::*;

    localparam int BUCKETS    = BUCKETS_DEF;
    localparam int WAYS       = WAYS_DEF;
    localparam int ENTRIES    = BUCKETS * WAYS;

    // The block answers the fourth opcode as an undefined symbol.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int RANDOM_OPS = 1900;
    localparam int HOT_KEYS   = 48;
    // Each group holds more keys than a bucket has ways, so it can overflow.
    localparam int GROUPS     = 6;
    localparam int GROUP_SIZE = WAYS + 3;
    localparam int TAIL_WAIT  = 30;
    localparam int LIMIT      = 1000000;
    localparam int SHOW_MAX   = 10;

    typedef struct {
        logic        [FUNC_W-1:0] func;
        logic        [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] value;
        int unsigned              gap;
        bit                       drain;
    } sym_op_t;

    typedef struct {
        logic        [WORD_W-1:0]   key;
        logic signed [WORD_W-1:0]   result_value;
        logic        [STATUS_W-1:0] status;
    } sym_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hst_req_if req ();
    hst_rsp_if rsp ();

    // Local copies of the driven signals so that every input is known from time zero.
    logic                     drv_valid = 1'b0;
    logic        [FUNC_W-1:0] drv_func  = FUNC_LOOKUP;
    logic        [WORD_W-1:0] drv_key   = '0;
    logic signed [WORD_W-1:0] drv_value = '0;
    logic                     drv_ready = 1'b0;

    assign req.valid = drv_valid;
    assign req.func  = drv_func;
    assign req.key   = drv_key;
    assign req.value = drv_value;
    assign rsp.ready = drv_ready;

    hashed_symbol_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the symbol store, tracked transfer by transfer.
    logic [KIND_W-1:0] sym_kind  [ENTRIES];
    logic [WORD_W-1:0] sym_key   [ENTRIES];
    logic [WORD_W-1:0] sym_value [ENTRIES];

    sym_op_t     pending_ops[$];
    sym_result_t pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // Driver state
    int unsigned send_gap = 0;
    bit          took;
    sym_result_t predicted;
    sym_op_t     next_op;

    // Receiver state
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;
    int unsigned roll;
    sym_result_t oldest;

    // Six-step integer mix of the key; its low part picks the bucket.
    function automatic logic [WORD_W-1:0] mix_key(input logic [WORD_W-1:0] k);
        k = (k + MIX_C0) + (k << 12);
        k = (k ^ MIX_C1) ^ (k >> 19);
        k = (k + MIX_C2) + (k << 5);
        k = (k + MIX_C3) ^ (k << 9);
        k = (k + MIX_C4) + (k << 3);
        k = (k ^ MIX_C5) ^ (k >> 16);
        return k;
    endfunction

    function automatic int unsigned bucket_of(input logic [WORD_W-1:0] key);
        return int'(mix_key(key) % BUCKETS);
    endfunction

    // Predict the answer to one operation and update the shadow store.
    function automatic sym_result_t apply_symbol_op(
        input logic        [FUNC_W-1:0] func,
        input logic        [WORD_W-1:0] key,
        input logic signed [WORD_W-1:0] value
    );
        sym_result_t       res;
        int unsigned       base;
        int unsigned       slot;
        int unsigned       free_slot;
        bit                hit;
        bit                has_free;
        logic [KIND_W-1:0] kind;
        res.key          = key;
        res.result_value = '0;
        res.status       = STATUS_UNDEF;
        if (func == FUNC_UNUSED)
            return res;
        base      = bucket_of(key) * WAYS;
        hit       = 1'b0;
        has_free  = 1'b0;
        slot      = 0;
        free_slot = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (sym_kind[base + w] == KIND_FREE)
            begin
                if (!has_free)
                begin
                    has_free  = 1'b1;
                    free_slot = base + w;
                end
            end
            else if (!hit && sym_key[base + w] == key)
            begin
                hit  = 1'b1;
                slot = base + w;
            end
        end
        if (!hit)
        begin
            // Absent key: take the lowest free way, or report the bucket full.
            if (!has_free)
            begin
                res.status = STATUS_FULL;
                return res;
            end
            slot            = free_slot;
            sym_kind[slot]  = KIND_UNDEF;
            sym_key[slot]   = key;
            sym_value[slot] = '0;
        end
        kind = sym_kind[slot];
        if (func == FUNC_LOOKUP)
        begin
            if (kind == KIND_TOKEN || kind == KIND_NUMBER)
            begin
                res.result_value = sym_value[slot];
                res.status       = STATUS_OK;
            end
        end
        else if (func == FUNC_DEF_TOKEN)
        begin
            if (kind != KIND_UNDEF)
                res.status = STATUS_REFUSED;
            else
            begin
                sym_kind[slot]   = KIND_TOKEN;
                sym_value[slot]  = value;
                res.result_value = value;
                res.status       = STATUS_OK;
            end
        end
        else
        begin
            if (kind == KIND_TOKEN)
                res.status = STATUS_REFUSED;
            else
            begin
                sym_kind[slot]   = KIND_NUMBER;
                sym_value[slot]  = value;
                res.result_value = value;
                res.status       = STATUS_OK;
            end
        end
        return res;
    endfunction

    // Mostly short idles, now and then a long one.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic sym_op_t make_op(
        input logic        [FUNC_W-1:0] func,
        input logic        [WORD_W-1:0] key,
        input logic signed [WORD_W-1:0] value
    );
        sym_op_t op;
        op.func  = func;
        op.key   = key;
        op.value = value;
        op.gap   = 0;
        op.drain = 1'b0;
        return op;
    endfunction

    // Free-running clock, 20 ns period; reset is held low once, at the start, then released.
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: end the run as failed once the cycle count reaches LIMIT.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT)
        begin
            $display("hashed_symbol_table test failed");
            $finish;
        end
    end

    // Driver: present the oldest pending operation, predict its answer on the
    // transfer, then idle for the gap that came with it. An operation marked
    // drain is held back until every predicted answer has been received.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took = drv_valid && req.ready;
            if (took)
            begin
                predicted = apply_symbol_op(drv_func, drv_key, drv_value);
                pending_results.push_back(predicted);
            end
            if (!drv_valid || took)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].drain && pending_results.size() != 0))
                begin
                    next_op   = pending_ops.pop_front();
                    drv_valid <= 1'b1;
                    drv_func  <= next_op.func;
                    drv_key   <= next_op.key;
                    drv_value <= next_op.value;
                    send_gap  = next_op.gap;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each response transfer against the oldest prediction,
    // then decide whether to stall the next cycle. Calm stretches keep ready
    // high for a while so back-to-back traffic is covered too.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && drv_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("unexpected response: value %0d status %0d",
                                 rsp.result_value, rsp.status);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (rsp.result_value !== oldest.result_value ||
                        rsp.status !== oldest.status)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX)
                            $display("mismatch key %h: expected value %0d status %0d, got value %0d status %0d",
                                     oldest.key, oldest.result_value, oldest.status,
                                     rsp.result_value, rsp.status);
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                drv_ready <= 1'b0;
            end
            else if (calm_left != 0)
            begin
                calm_left--;
                drv_ready <= 1'b1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    calm_left = $urandom_range(50, 300);
                else if (roll < 25)
                    stall_left = idle_length();
                drv_ready <= (roll >= 3 && roll < 25) ? 1'b0 : 1'b1;
            end
        end
    end

    // Stimulus: build colliding key groups, queue the directed operations and
    // the random mix, then wait for the traffic to drain and report.
    logic [WORD_W-1:0] hot_key   [HOT_KEYS];
    logic [WORD_W-1:0] group_key [GROUPS][GROUP_SIZE];

    initial
    begin
        logic [WORD_W-1:0]        probe;
        logic [WORD_W-1:0]        key;
        logic signed [WORD_W-1:0] value;
        logic [FUNC_W-1:0]        func;
        int unsigned              target;
        int unsigned              found;
        int unsigned              quiet;
        int unsigned              pick;
        sym_op_t                  op;

        for (int i = 0; i < ENTRIES; i++)
            sym_kind[i] = KIND_FREE;

        for (int i = 0; i < HOT_KEYS; i++)
            hot_key[i] = $urandom;

        // Search upward from a random key for others that land in its bucket.
        for (int g = 0; g < GROUPS; g++)
        begin
            probe           = $urandom;
            target          = bucket_of(probe);
            group_key[g][0] = probe;
            found           = 1;
            while (found < GROUP_SIZE)
            begin
                probe++;
                if (bucket_of(probe) == target)
                begin
                    group_key[g][found] = probe;
                    found++;
                end
            end
        end

        // New key: a lookup enters it as undefined, and it stays undefined.
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'sd0));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'sd0));
        // Token on an undefined key, then refused redefinitions of a token.
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, 32'h0000_0000, 32'h7fff_ffff));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h0000_0000, 32'sd0));
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, 32'h0000_0000, 32'sd5));
        pending_ops.push_back(make_op(FUNC_DEF_NUMBER, 32'h0000_0000, 32'sd6));
        // Number on a new key, overwrite it, refuse a token over it.
        pending_ops.push_back(make_op(FUNC_DEF_NUMBER, 32'hffff_ffff, 32'h8000_0000));
        pending_ops.push_back(make_op(FUNC_DEF_NUMBER, 32'hffff_ffff, -32'sd1));
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, 32'hffff_ffff, 32'sd7));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'hffff_ffff, 32'sd0));
        pending_ops.push_back(make_op(FUNC_UNUSED, 32'hffff_ffff, 32'h7fff_ffff));
        // Token straight onto a new key; token and number onto undefined keys.
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, 32'haaaa_aaaa, 32'sd0));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h5555_5555, 32'sd0));
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, 32'h5555_5555, 32'h5555_5555));
        pending_ops.push_back(make_op(FUNC_LOOKUP, 32'h1234_5678, 32'sd0));
        pending_ops.push_back(make_op(FUNC_DEF_NUMBER, 32'h1234_5678, 32'haaaa_aaaa));
        // Fill one bucket, then overflow it with every opcode.
        for (int w = 0; w < WAYS; w++)
            pending_ops.push_back(make_op(FUNC_DEF_NUMBER, group_key[0][w], $urandom));
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, group_key[0][WAYS], 32'sd1));
        pending_ops.push_back(make_op(FUNC_LOOKUP, group_key[0][WAYS], 32'sd0));
        pending_ops.push_back(make_op(FUNC_DEF_NUMBER, group_key[0][WAYS], 32'sd2));
        pending_ops.push_back(make_op(FUNC_UNUSED, group_key[0][WAYS], 32'sd3));
        pending_ops.push_back(make_op(FUNC_LOOKUP, group_key[0][2], 32'sd0));
        pending_ops.push_back(make_op(FUNC_DEF_TOKEN, group_key[0][1], 32'sd4));

        // Random mix: mostly keys that recur, so defines and lookups meet.
        quiet = 0;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                key = hot_key[$urandom_range(0, HOT_KEYS - 1)];
            else if (pick < 70)
                key = group_key[$urandom_range(0, GROUPS - 1)][$urandom_range(0, GROUP_SIZE - 1)];
            else if (pick < 72)
                key = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
            else
                key = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 38)
                func = FUNC_LOOKUP;
            else if (pick < 64)
                func = FUNC_DEF_TOKEN;
            else if (pick < 94)
                func = FUNC_DEF_NUMBER;
            else
                func = FUNC_UNUSED;

            pick = $urandom_range(0, 99);
            if (pick < 4)
                value = 32'h7fff_ffff;
            else if (pick < 8)
                value = 32'h8000_0000;
            else if (pick < 12)
                value = $urandom_range(0, 15);
            else
                value = $urandom;

            op = make_op(func, key, value);
            // Alternate idle periods with runs of back-to-back requests.
            if (quiet != 0)
                quiet--;
            else if ($urandom_range(0, 99) < 2)
                quiet = $urandom_range(20, 80);
            else
                op.gap = idle_length();
            // Hold the sender until the block is empty a few times.
            op.drain = (i == 0 || i == RANDOM_OPS / 3 || i == 2 * RANDOM_OPS / 3);
            pending_ops.push_back(op);
        end

        // Wait for every request to transfer and every response to return.
        while (pending_ops.size() != 0 || drv_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("hashed_symbol_table test passed");
        else
            $display("hashed_symbol_table test failed");
        $finish;
    end

endmodule
